@@ hdl/vector_table_exact_match_search_core_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the vector table search core
// ----------------------------------------------------------------------------
`ifndef VECTOR_TABLE_EXACT_MATCH_SEARCH_CORE_ASSERT_SVH
`define VECTOR_TABLE_EXACT_MATCH_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define VTEM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vtem_pkg.sv @@
// ----------------------------------------------------------------------------
// vtem_pkg
// types and constants shared by the vector table search core
// ----------------------------------------------------------------------------
package vtem_pkg;

  localparam int MAX_VECTORS_DEF = 16;
  localparam int MAX_LEN_DEF     = 16;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_LONG = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [63:0] element;
    logic        last;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic       matched;
    logic [3:0] index;
    logic [1:0] error;
  } result_t;

endpackage

@@ hdl/vtem_stream_if.sv @@
// ----------------------------------------------------------------------------
// vtem_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface vtem_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/vector_table_exact_match_search_core.sv @@
// ----------------------------------------------------------------------------
// vector_table_exact_match_search_core
// stores streamed vectors and searches them for an exact match
//
// channel   dir  payload   transaction
// item      in   item_t    one element; last ends a vector or query
// result    out  result_t  one per element with last set
//
// elements and appends are accepted back to back while no result blocks
// a search walks the table: a length check per slot in ST_LEN, then each
//   compared element is read in ST_RD and compared in ST_CHK through the
//   single element memory port
// item.ready is low during a search and while an undrained result blocks
// rst is synchronous; memories are not cleared
// ----------------------------------------------------------------------------
`include "vector_table_exact_match_search_core_assert.svh"

module vector_table_exact_match_search_core
  import vtem_pkg::*;
#(
  parameter int MAX_VECTORS = MAX_VECTORS_DEF,
  parameter int MAX_LEN     = MAX_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  vtem_stream_if.sink         item,
  vtem_stream_if.source       result
);

  localparam int SW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
  localparam int CW = $clog2(MAX_VECTORS + 1);
  localparam int KW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_VECTORS * MAX_LEN;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_CHK  = 2'd3;

  logic [63:0] element_mem [DEPTH];
  logic [63:0] query_mem [MAX_LEN];
  logic [LW-1:0] length_store [MAX_VECTORS];

  logic [1:0]    state;
  logic [CW-1:0] vector_count;
  logic [LW-1:0] fill_position;
  logic          overflow_flag;
  logic [CW-1:0] slot;
  logic [KW-1:0] pos;
  logic [LW-1:0] query_len;
  logic [63:0]   elem_rd;
  logic [63:0]   query_rd;
  logic          out_valid;
  result_t       out_data;

  logic          accept;
  logic          fill_fits;
  logic [LW-1:0] len_now;
  logic          ovf_now;
  logic          has_room;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [SW+3:0] count_wide;
  logic [SW+3:0] slot_wide;
  logic          append_end;
  logic          search_end;
  logic          chk_last;
  logic          out_load;
  logic          out_err;
  logic          out_hit;

  assign item.ready   = (state == ST_IDLE) && (!out_valid || result.ready);
  assign accept       = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign fill_fits = fill_position < LW'(MAX_LEN);
  assign len_now   = fill_fits ? fill_position + LW'(1) : fill_position;
  assign ovf_now   = overflow_flag || !fill_fits;
  assign has_room  = vector_count < CW'(MAX_VECTORS);

  assign wr_addr = AW'(vector_count) * AW'(MAX_LEN) + AW'(fill_position);
  assign rd_addr = AW'(slot) * AW'(MAX_LEN) + AW'(pos);

  assign count_wide = {4'b0, vector_count[SW-1:0]};
  assign slot_wide  = {4'b0, slot[SW-1:0]};

  assign append_end = accept && item.data.last && !ovf_now && item.data.mode == MODE_APPEND;
  assign search_end = accept && item.data.last && !ovf_now && item.data.mode == MODE_SEARCH;
  assign chk_last   = (LW'(pos) + LW'(1) == query_len);

  assign out_err = out_valid && (out_data.error != ERR_NONE);
  assign out_hit = out_valid && out_data.matched;

  // a result transaction is loaded this cycle
  always_comb begin
    case (state)
      ST_IDLE: out_load = accept && item.data.last && !search_end;
      ST_LEN:  out_load = (slot == vector_count);
      ST_CHK:  out_load = (elem_rd == query_rd) && chk_last;
      default: out_load = 1'b0;
    endcase
  end

  // element and query memories
  always_ff @(posedge clk) begin
    if (accept && fill_fits) begin
      query_mem[fill_position[KW-1:0]] <= item.data.element;
      if (has_room) begin
        element_mem[wr_addr] <= item.data.element;
      end
    end
    elem_rd  <= element_mem[rd_addr];
    query_rd <= query_mem[pos];
  end

  always_ff @(posedge clk) begin
    if (append_end && has_room) begin
      length_store[vector_count[SW-1:0]] <= len_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      vector_count  <= '0;
      fill_position <= '0;
      overflow_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !result.ready);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!item.data.last) begin
              fill_position <= len_now;
              overflow_flag <= ovf_now;
            end else begin
              fill_position    <= '0;
              overflow_flag    <= 1'b0;
              out_data.kind    <= item.data.mode;
              out_data.matched <= 1'b0;
              if (ovf_now) begin
                out_data.index <= '0;
                out_data.error <= ERR_LONG;
              end else if (item.data.mode == MODE_APPEND) begin
                if (has_room) begin
                  out_data.index <= count_wide[3:0];
                  out_data.error <= ERR_NONE;
                  vector_count   <= vector_count + CW'(1);
                end else begin
                  out_data.index <= '0;
                  out_data.error <= ERR_FULL;
                end
              end else begin
                out_data.index <= '0;
                out_data.error <= ERR_NONE;
                query_len      <= len_now;
                slot           <= '0;
                state          <= ST_LEN;
              end
            end
          end
        end
        ST_LEN: begin
          pos <= '0;
          if (slot == vector_count) begin
            state <= ST_IDLE;
          end else if (length_store[slot[SW-1:0]] != query_len) begin
            slot <= slot + CW'(1);
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (elem_rd != query_rd) begin
            slot  <= slot + CW'(1);
            state <= ST_LEN;
          end else if (chk_last) begin
            out_data.matched <= 1'b1;
            out_data.index   <= slot_wide[3:0];
            state            <= ST_IDLE;
          end else begin
            pos   <= pos + KW'(1);
            state <= ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `VTEM_ASSERT_NOW(a_busy_not_ready, state != ST_IDLE, !item.ready, "ready during search")
  `VTEM_ASSERT_NOW(a_count_bound, 1'b1, vector_count <= CW'(MAX_VECTORS), "vector count overflow")
  `VTEM_ASSERT_NOW(a_err_no_match, out_err, !out_data.matched, "match with error")
  `VTEM_ASSERT_NOW(a_match_is_search, out_hit, out_data.kind == KIND_SEARCH, "match on append")
  `VTEM_ASSERT_NEXT(a_search_starts, search_end, state == ST_LEN && !out_valid, "search not started")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench for vector_table_exact_match_search_core
// streams appends, searches and noise with random idling on both channels;
// a local table predictor checks every result transaction in order
// ----------------------------------------------------------------------------
module testbench;
  import vtem_pkg::*;

  localparam int NUM_VECTORS  = MAX_VECTORS_DEF;
  localparam int VEC_LEN      = MAX_LEN_DEF;
  localparam int NUM_ITEMS    = 550;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 600;
  localparam int LONG_HOLD    = 400;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    item_t it;
    bit    drain;
  } pending_t;

  logic clk = 1'b0;
  logic rst;

  vtem_stream_if #(.T(item_t))   item_ch ();
  vtem_stream_if #(.T(result_t)) result_ch ();

  vector_table_exact_match_search_core uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // table predictor state
  logic [63:0] table_elem [NUM_VECTORS][VEC_LEN];
  int          table_len [NUM_VECTORS];
  int          table_count = 0;
  logic [63:0] stage_elem [VEC_LEN];
  int          stage_len = 0;
  bit          stage_over = 0;

  result_t  expected_results [$];
  pending_t pending_items [$];
  pending_t next_item;
  int       n_predicted = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       idle_cycles = 0;

  // stimulus scratch and history of appended vectors
  logic [63:0] vec_buf [$];
  logic [63:0] pool_elem [POOL_SIZE][VEC_LEN];
  int          pool_len [POOL_SIZE];
  int          pool_n = 0;
  int          pool_next = 0;
  int          items_queued = 0;

  task automatic report(input string msg);
    n_errors++;
    $display("error at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
    if (got !== want)
      report($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  function automatic void predict_result(input item_t it);
    result_t r;
    bit      same;
    if (stage_len < VEC_LEN) begin
      stage_elem[stage_len] = it.element;
      stage_len++;
    end else begin
      stage_over = 1'b1;
    end
    if (!it.last) return;
    r.kind    = (it.mode == MODE_SEARCH) ? KIND_SEARCH : KIND_APPEND;
    r.matched = 1'b0;
    r.index   = 4'd0;
    r.error   = ERR_NONE;
    if (stage_over) begin
      r.error = ERR_LONG;
    end else if (it.mode == MODE_APPEND) begin
      if (table_count >= NUM_VECTORS) begin
        r.error = ERR_FULL;
      end else begin
        for (int k = 0; k < stage_len; k++) table_elem[table_count][k] = stage_elem[k];
        table_len[table_count] = stage_len;
        r.index = table_count[3:0];
        table_count++;
      end
    end else begin
      for (int s = 0; s < table_count && !r.matched; s++) begin
        same = (table_len[s] == stage_len);
        for (int k = 0; k < stage_len && same; k++)
          if (table_elem[s][k] != stage_elem[k]) same = 1'b0;
        if (same) begin
          r.matched = 1'b1;
          r.index   = s[3:0];
        end
      end
    end
    stage_len  = 0;
    stage_over = 1'b0;
    expected_results.insert(expected_results.size(), r);
    n_predicted++;
  endfunction

  function automatic logic [63:0] rand_element();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return '1;
      2, 3: return 64'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 4);
    if (r < 88) return VEC_LEN;
    if (r < 94) return $urandom_range(5, VEC_LEN - 1);
    return $urandom_range(VEC_LEN + 1, VEC_LEN + 2);
  endfunction

  task automatic load_random(input int len);
    vec_buf.delete();
    repeat (len) vec_buf.insert(vec_buf.size(), rand_element());
  endtask

  task automatic load_pool(input int idx);
    vec_buf.delete();
    for (int k = 0; k < pool_len[idx]; k++) vec_buf.insert(vec_buf.size(), pool_elem[idx][k]);
  endtask

  task automatic send_vector(input logic mode_end, input bit mixed, input bit drain);
    pending_t p;
    int       n;
    n = vec_buf.size();
    for (int i = 0; i < n; i++) begin
      p.it.mode    = (i == n - 1 || !mixed) ? mode_end : logic'($urandom_range(1));
      p.it.element = vec_buf[i];
      p.it.last    = (i == n - 1);
      p.drain      = drain && (i == 0);
      pending_items.insert(pending_items.size(), p);
      items_queued++;
    end
    if (mode_end == MODE_APPEND && n <= VEC_LEN) begin
      for (int k = 0; k < n; k++) pool_elem[pool_next][k] = vec_buf[k];
      pool_len[pool_next] = n;
      pool_next = (pool_next + 1) % POOL_SIZE;
      if (pool_n < POOL_SIZE) pool_n++;
    end
  endtask

  // driver
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) predict_result(item_ch.data);
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (pending_items.size() == 0 ||
                     (pending_items[0].drain && n_checked != n_predicted)) begin
          item_ch.valid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          item_ch.data  <= next_item.it;
          item_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = $urandom_range(1) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor and receiver stalls
  int  hold_left = 0;
  bit  hold_done = 0;
  int  seg_left = 0;
  int  stall_pct = 0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 4'(result_ch.data.kind), 4'(want.kind));
          check_field("matched", 4'(result_ch.data.matched), 4'(want.matched));
          check_field("index", result_ch.data.index, want.index);
          check_field("error", 4'(result_ch.data.error), 4'(want.error));
        end
        n_checked <= n_checked + 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && n_checked >= 40) begin
        // long hold-off so the block backs up into its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        result_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 60;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int  random_start;
  int  sel;
  int  pos;
  bit  mixed;
  bit  drain;

  initial begin
    rst = 1'b1;

    // directed: empty table, extremes, duplicates, length mismatch, mixed modes
    vec_buf = '{64'd0};
    send_vector(MODE_SEARCH, 0, 0);
    send_vector(MODE_APPEND, 0, 0);
    vec_buf = '{'1};
    send_vector(MODE_APPEND, 0, 0);
    send_vector(MODE_APPEND, 0, 0);
    send_vector(MODE_SEARCH, 0, 0);
    vec_buf = '{64'd0, '1};
    send_vector(MODE_SEARCH, 1, 0);
    vec_buf = '{64'd0};
    send_vector(MODE_SEARCH, 0, 0);
    vec_buf = '{64'h8000_0000_0000_0001, 64'h7ff0_0000_0000_0000};
    send_vector(MODE_APPEND, 1, 0);
    vec_buf = '{64'h8000_0000_0000_0001};
    send_vector(MODE_SEARCH, 0, 0);
    vec_buf = '{64'h8000_0000_0000_0001, 64'h7ff0_0000_0000_0000};
    send_vector(MODE_SEARCH, 1, 1);

    // random: appends, searches mostly replaying earlier vectors, some noise
    random_start = items_queued;
    while (items_queued - random_start < NUM_ITEMS) begin
      sel   = $urandom_range(99);
      mixed = ($urandom_range(99) < 30);
      drain = (items_queued == random_start) || ($urandom_range(99) < 4);
      if (sel < 35) begin
        if (pool_n > 0 && $urandom_range(99) < 30) load_pool($urandom_range(pool_n - 1));
        else load_random(pick_len());
        send_vector(MODE_APPEND, mixed, drain);
      end else if (sel < 88) begin
        if (pool_n > 0 && $urandom_range(99) < 75) begin
          load_pool($urandom_range(pool_n - 1));
          case ($urandom_range(5))
            0: begin
              pos = $urandom_range(vec_buf.size() - 1);
              vec_buf[pos] = vec_buf[pos] ^ (64'd1 << $urandom_range(63));
            end
            1: vec_buf.insert(vec_buf.size(), rand_element());
            2: if (vec_buf.size() > 1) vec_buf.delete(vec_buf.size() - 1);
            default: ;
          endcase
        end else begin
          load_random(pick_len());
        end
        send_vector(MODE_SEARCH, mixed, drain);
      end else begin
        load_random($urandom_range(1, 3));
        send_vector(logic'($urandom_range(1)), 1, drain);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_ch.valid) @(posedge clk);
    while (n_checked != n_predicted) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report($sformatf("%0d expected results never arrived", expected_results.size()));

    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
